// File: rtl/atss_pkg.sv
`default_nettype none

package atss_pkg;

  localparam int unsigned TEX_WIDTH  = 64;
  localparam int unsigned TEX_HEIGHT = 64;
  localparam int unsigned MAX_SPAN   = 64;

  localparam int unsigned MEM_DEPTH = 4096;
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned TEXEL_W   = 32;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;

  // texture sizes are powers of two, so repeat and mirror folding is a mask and a bit test
  localparam logic [COORD_W:0] TEX_W_SIZE = (COORD_W + 1)'(TEX_WIDTH);
  localparam logic [COORD_W:0] TEX_H_SIZE = (COORD_W + 1)'(TEX_HEIGHT);
  localparam logic [COUNT_W-1:0] SPAN_MAX = COUNT_W'(MAX_SPAN);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SPAN  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_XX    = 3'd0,
    CFG_INV_XY    = 3'd1,
    CFG_INV_XT    = 3'd2,
    CFG_INV_YX    = 3'd3,
    CFG_INV_YY    = 3'd4,
    CFG_INV_YT    = 3'd5,
    CFG_TILE_MODE = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TILE_CLAMP  = 2'd0,
    TILE_REPEAT = 2'd1,
    TILE_MIRROR = 2'd2
  } tile_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_OFS,
    ST_RUN
  } atss_state_e;

  typedef struct packed {
    logic                opcode;
    logic [ADDR_W-1:0]   texel_index;
    logic [TEXEL_W-1:0]  texel_value;
    logic [COORD_W-1:0]  dest_x;
    logic [COORD_W-1:0]  dest_y;
    logic [COUNT_W-1:0]  span_count;
  } in_item_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] pixel_out;
    logic               last_pixel;
  } out_item_t;

  typedef struct packed {
    logic tex_we;
    logic load;
    logic mul;
    logic sum;
    logic ofs;
    logic issue;
    logic last;
  } atss_cmd_t;

  typedef struct packed {
    logic advance;
    logic pipe_empty;
  } atss_sts_t;

  function automatic logic [COORD_W-1:0] fold_coord(logic signed [31:0] c, logic [1:0] mode,
                                                    logic [COORD_W:0] size);
    logic [COORD_W-1:0] mask;
    logic [COORD_W-1:0] low;
    logic               flip;
    logic signed [31:0] lim;
    logic [COORD_W-1:0] res;
    mask = COORD_W'(size - (COORD_W + 1)'(1));
    low  = c[COORD_W-1:0] & mask;
    flip = |(c[COORD_W:0] & size);
    lim  = $signed({{(31 - COORD_W){1'b0}}, size}) - 32'sd1;
    unique case (mode)
      TILE_REPEAT: res = low;
      TILE_MIRROR: res = flip ? (~c[COORD_W-1:0] & mask) : low;
      default: begin
        if (c < 32'sd0) begin
          res = '0;
        end else if (c > lim) begin
          res = mask;
        end else begin
          res = c[COORD_W-1:0];
        end
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/affine_texture_span_sampler.sv
// Affine texture span sampler.
// Input channel (in_valid_i / in_ready_o / in_item_i) carries two kinds of item:
// a texel write, stored into the 4096-word texture memory at the accepting edge,
// and a span, which maps each pixel centre through the inverse affine matrix,
// folds the texel coordinate by the tile mode and emits one pixel per position.
// Output channel (out_valid_o / out_ready_i / out_item_o) carries one pixel per
// item, last_pixel set on the final pixel of a span.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at once;
// write it only while the block is idle.
// Timing: a write item is accepted while idle and leaves the block idle. A span
// first runs the setup states MUL, SUM and OFS (four parallel 32x29 multiplies,
// a sum, the translation add), then issues one pixel a cycle, while the output
// is not stalled, from the coordinate accumulators; the next item is taken once
// the address and read stages of the three-stage fetch pipeline have drained.
// A stalled receiver freezes the accumulators, fetch pipeline and output
// register together; nothing is lost. Reset restores identity matrix and clamp
// mode, empties the pipeline; texture contents are undefined until written.
`default_nettype none

module affine_texture_span_sampler
  import atss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o
);

  atss_cmd_t cmd;
  atss_sts_t sts;

  atss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  atss_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: rtl/atss_ram.sv
`default_nettype none

module atss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/atss_ctrl.sv
`default_nettype none

module atss_ctrl
  import atss_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire in_item_t  in_item_i,
  output logic           in_ready_o,
  input  wire atss_sts_t sts_i,
  output atss_cmd_t      cmd_o
);

  atss_state_e        state_q, state_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0] cnt_sat;
  logic               accept;

  assign cnt_sat = (in_item_i.span_count > SPAN_MAX) ? SPAN_MAX : in_item_i.span_count;
  assign accept  = in_valid_i && sts_i.pipe_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.pipe_empty;
        if (accept) begin
          if (in_item_i.opcode == OP_WRITE) begin
            cmd_o.tex_we = 1'b1;
          end else if (cnt_sat != '0) begin
            cmd_o.load = 1'b1;
            cnt_d      = cnt_sat;
            state_d    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_OFS;
      end
      ST_OFS: begin
        cmd_o.ofs = 1'b1;
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.advance) begin
          cmd_o.issue = 1'b1;
          cmd_o.last  = (cnt_q == COUNT_W'(1));
          cnt_d       = cnt_q - COUNT_W'(1);
          if (cnt_q == COUNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/atss_datapath.sv
`default_nettype none

module atss_datapath
  import atss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire in_item_t             in_item_i,
  input  wire atss_cmd_t            cmd_i,
  output atss_sts_t                 sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o
);

  logic signed [31:0] inv_xx_q, inv_xy_q, inv_xt_q, inv_yx_q, inv_yy_q, inv_yt_q;
  logic [1:0]         tile_mode_q;

  logic [27:0]        px_q, py_q;
  logic signed [60:0] p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  logic signed [63:0] sx_q, sy_q;

  logic [COORD_W-1:0] col, row;
  logic [ADDR_W-1:0]  addr_d, addr_q;
  logic               s1_vld_q, s1_last_q;
  logic               s2_vld_q, s2_last_q;
  logic               out_vld_q;
  out_item_t          out_item_q;
  logic [TEXEL_W-1:0] rdata;
  logic               advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_xx_q    <= 32'sd65536;
      inv_xy_q    <= '0;
      inv_xt_q    <= '0;
      inv_yx_q    <= '0;
      inv_yy_q    <= 32'sd65536;
      inv_yt_q    <= '0;
      tile_mode_q <= TILE_CLAMP;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INV_XX:    inv_xx_q    <= $signed(cfg_data_i);
        CFG_INV_XY:    inv_xy_q    <= $signed(cfg_data_i);
        CFG_INV_XT:    inv_xt_q    <= $signed(cfg_data_i);
        CFG_INV_YX:    inv_yx_q    <= $signed(cfg_data_i);
        CFG_INV_YY:    inv_yy_q    <= $signed(cfg_data_i);
        CFG_INV_YT:    inv_yt_q    <= $signed(cfg_data_i);
        CFG_TILE_MODE: tile_mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= {in_item_i.dest_x, 1'b1, 15'd0};
      py_q <= {in_item_i.dest_y, 1'b1, 15'd0};
    end
    if (cmd_i.mul) begin
      p_xx_q <= inv_xx_q * $signed({1'b0, px_q});
      p_xy_q <= inv_xy_q * $signed({1'b0, py_q});
      p_yx_q <= inv_yx_q * $signed({1'b0, px_q});
      p_yy_q <= inv_yy_q * $signed({1'b0, py_q});
    end
    if (cmd_i.sum) begin
      sx_q <= {{3{p_xx_q[60]}}, p_xx_q} + {{3{p_xy_q[60]}}, p_xy_q};
      sy_q <= {{3{p_yx_q[60]}}, p_yx_q} + {{3{p_yy_q[60]}}, p_yy_q};
    end else if (cmd_i.ofs) begin
      sx_q <= sx_q + {{16{inv_xt_q[31]}}, inv_xt_q, 16'd0};
      sy_q <= sy_q + {{16{inv_yt_q[31]}}, inv_yt_q, 16'd0};
    end else if (cmd_i.issue) begin
      sx_q <= sx_q + {{16{inv_xx_q[31]}}, inv_xx_q, 16'd0};
      sy_q <= sy_q + {{16{inv_yx_q[31]}}, inv_yx_q, 16'd0};
    end
  end

  assign col    = fold_coord($signed(sx_q[63:32]), tile_mode_q, TEX_W_SIZE);
  assign row    = fold_coord($signed(sy_q[63:32]), tile_mode_q, TEX_H_SIZE);
  assign addr_d = ADDR_W'(row * ADDR_W'(TEX_WIDTH)) + col;

  assign advance = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q  <= cmd_i.issue;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      addr_q                <= addr_d;
      s1_last_q             <= cmd_i.last;
      s2_last_q             <= s1_last_q;
      out_item_q.pixel_out  <= rdata;
      out_item_q.last_pixel <= s2_last_q;
    end
  end

  atss_ram #(
    .WIDTH(TEXEL_W),
    .DEPTH(MEM_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tex_we),
    .waddr_i (in_item_i.texel_index),
    .wdata_i (in_item_i.texel_value),
    .re_i    (advance),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign sts_o.advance    = advance;
  assign sts_o.pipe_empty = !s1_vld_q && !s2_vld_q;
  assign out_valid_o      = out_vld_q;
  assign out_item_o       = out_item_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_affine_texture_span_sampler.sv
`timescale 1ns / 1ps

module tb_affine_texture_span_sampler
  import atss_pkg::*;
;

  localparam logic [1:0] TILE_UNUSED = 2'd3;
  localparam int         LOAD_CAP    = 3;

  class pixel_scoreboard;
    logic [TEXEL_W-1:0]  texels [MEM_DEPTH];
    bit                  texel_written [MEM_DEPTH];
    logic signed [31:0]  coef [7];
    logic [1:0]          mode;
    out_item_t           pending_pixels [$];
    int unsigned         fails;

    function new();
      foreach (texels[a]) begin
        texels[a] = '0;
        texel_written[a] = 1'b0;
      end
      foreach (coef[r]) coef[r] = '0;
      coef[CFG_INV_XX] = 32'sh0001_0000;
      coef[CFG_INV_YY] = 32'sh0001_0000;
      mode = TILE_CLAMP;
      fails = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      if (idx == CFG_TILE_MODE) begin
        mode = v[1:0];
      end else begin
        coef[idx] = v;
      end
    endfunction

    function int span_len(logic [COUNT_W-1:0] cnt);
      return (cnt > SPAN_MAX) ? int'(SPAN_MAX) : int'(cnt);
    endfunction

    function longint wrap_coord(longint c, longint size);
      longint m;
      if (mode == TILE_REPEAT) begin
        m = c % size;
        if (m < 0) m += size;
        return m;
      end
      if (mode == TILE_MIRROR) begin
        m = c % (2 * size);
        if (m < 0) m += 2 * size;
        if (m >= size) m = 2 * size - 1 - m;
        return m;
      end
      if (c < 0) return 0;
      if (c > size - 1) return size - 1;
      return c;
    endfunction

    // texel address sampled by pixel i of a span starting at (dx, dy)
    function int sample_addr(logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy, int i);
      longint px, py, sx, sy, col, row;
      px  = (longint'(dx) + longint'(i)) * 65536 + 32768;
      py  = longint'(dy) * 65536 + 32768;
      sx  = longint'(coef[CFG_INV_XX]) * px + longint'(coef[CFG_INV_XY]) * py
          + longint'(coef[CFG_INV_XT]) * 65536;
      sy  = longint'(coef[CFG_INV_YX]) * px + longint'(coef[CFG_INV_YY]) * py
          + longint'(coef[CFG_INV_YT]) * 65536;
      col = wrap_coord(sx >>> 32, longint'(TEX_WIDTH));
      row = wrap_coord(sy >>> 32, longint'(TEX_HEIGHT));
      return int'((row * longint'(TEX_WIDTH) + col) & longint'(MEM_DEPTH - 1));
    endfunction

    function void note_item(in_item_t it);
      out_item_t e;
      int        n;
      if (it.opcode == OP_WRITE) begin
        texels[it.texel_index] = it.texel_value;
        texel_written[it.texel_index] = 1'b1;
      end else begin
        n = span_len(it.span_count);
        for (int i = 0; i < n; i++) begin
          e.pixel_out  = texels[sample_addr(it.dest_x, it.dest_y, i)];
          e.last_pixel = (i == n - 1);
          pending_pixels.push_back(e);
        end
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t exp;
      if (pending_pixels.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected pixel %08h last %0b", got.pixel_out, got.last_pixel);
      end else begin
        exp = pending_pixels.pop_front();
        if (got.pixel_out !== exp.pixel_out || got.last_pixel !== exp.last_pixel) begin
          fails++;
          if (fails <= 10)
            $display("pixel mismatch: expected %08h last %0b, got %08h last %0b",
                     exp.pixel_out, exp.last_pixel, got.pixel_out, got.last_pixel);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  bit                   calm = 1'b0;
  pixel_scoreboard      sb;

  affine_texture_span_sampler u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_pixel(out_item);
      out_ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode      = 1'($urandom_range(1));
    it.texel_index = ADDR_W'($urandom);
    it.texel_value = $urandom;
    it.dest_x      = COORD_W'($urandom);
    it.dest_y      = COORD_W'($urandom);
    it.span_count  = COUNT_W'($urandom);
    return it;
  endfunction

  task automatic push(in_item_t it);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_texel(logic [ADDR_W-1:0] idx, logic [TEXEL_W-1:0] val);
    in_item_t it;
    it             = rand_item();
    it.opcode      = OP_WRITE;
    it.texel_index = idx;
    it.texel_value = val;
    push(it);
  endtask

  // load every texel the span will sample that has not been loaded yet, then send the span
  task automatic send_span(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COUNT_W-1:0] cnt);
    in_item_t it;
    int       a;
    for (int i = 0; i < sb.span_len(cnt); i++) begin
      a = sb.sample_addr(x, y, i);
      if (!sb.texel_written[a]) send_texel(ADDR_W'(a), $urandom);
    end
    it            = rand_item();
    it.opcode     = OP_SPAN;
    it.dest_x     = x;
    it.dest_y     = y;
    it.span_count = cnt;
    push(it);
  endtask

  function automatic int loads_needed(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      logic [COUNT_W-1:0] cnt);
    int n;
    n = 0;
    for (int i = 0; i < sb.span_len(cnt); i++) begin
      if (!sb.texel_written[sb.sample_addr(x, y, i)]) n++;
    end
    return n;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_coef(int p);
    if (p == 0) return 32'h7FFF_FFFF;
    if (p == 1) return 32'h8000_0000;
    case ($urandom_range(5))
      0: return $urandom;
      1: return '0;
      2: return 32'h0001_0000;
      3: return $urandom_range(0, 2 ** 19) - 2 ** 18;
      4: return 32'hFFFF_0000;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic run_random(int n);
    logic [COORD_W-1:0] x, y;
    logic [COUNT_W-1:0] cnt;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 35) begin
        send_texel(ADDR_W'($urandom), $urandom);
      end else begin
        case ($urandom_range(9))
          0: cnt = '0;
          1: cnt = COUNT_W'($urandom_range(65, 127));
          default: cnt = COUNT_W'($urandom_range(1, 64));
        endcase
        x = COORD_W'(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(127));
        y = COORD_W'(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(127));
        // shorten the span while it would need too many texture loads
        while (cnt > COUNT_W'(1) && loads_needed(x, y, cnt) > LOAD_CAP) cnt = cnt >> 1;
        send_span(x, y, cnt);
      end
    end
  endtask

  initial begin
    logic [1:0]       tile;
    logic [CFG_W-1:0] tile_word;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_texel(12'd0, 32'h0000_0000);
    send_texel(12'd4095, 32'hFFFF_FFFF);
    send_texel(12'd63, 32'hA5C3_3C5A);
    send_span(12'd0, 12'd0, 7'd1);
    send_span(12'd4095, 12'd4095, 7'd64);
    send_span(12'd4000, 12'd0, 7'd127);
    send_span(12'd0, 12'd0, 7'd0);
    send_span(12'd0, 12'd4095, 7'd2);
    send_texel(12'd4095, 32'h5A3C_C3A5);
    send_span(12'd4095, 12'd63, 7'd1);
    send_span(12'd100, 12'd2000, 7'd5);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: tile = TILE_MIRROR;
        1: tile = TILE_UNUSED;
        2: tile = TILE_REPEAT;
        3: tile = TILE_CLAMP;
        4: tile = TILE_MIRROR;
        default: tile = 2'($urandom_range(3));
      endcase
      tile_word      = $urandom;
      tile_word[1:0] = tile;
      write_reg(CFG_INV_XX, pick_coef(p));
      write_reg(CFG_INV_XY, pick_coef(p));
      write_reg(CFG_INV_XT, pick_coef(p));
      write_reg(CFG_INV_YX, pick_coef(p));
      write_reg(CFG_INV_YY, pick_coef(p));
      write_reg(CFG_INV_YT, pick_coef(p));
      write_reg(CFG_TILE_MODE, tile_word);
      cfg_we <= 1'b0;
      @(posedge clk);
      calm = (p == 3);
      run_random(13);
    end

    drain();
    if (sb.fails == 0 && sb.pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/atss_pkg.sv
rtl/atss_ram.sv
rtl/atss_ctrl.sv
rtl/atss_datapath.sv
rtl/affine_texture_span_sampler.sv
tb/sv/tb_affine_texture_span_sampler.sv
